[hw/rtl/npcs_pkg.sv]
package npcs_pkg;

  localparam int unsigned COLOR_W = 18;
  localparam int unsigned DIST_W  = 12;
  localparam int unsigned SQ_W    = 10;
  localparam int unsigned CHAN_SHIFT   = 3;
  localparam int unsigned A_SHIFT      = 5;
  localparam int unsigned ALPHA_LEVELS = 8;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // stored palette word, alpha in the top bits
  typedef struct packed {
    logic [2:0] a;
    logic [4:0] b;
    logic [4:0] g;
    logic [4:0] r;
  } color_t;

  // per-channel squared differences, alpha already weighted
  typedef struct packed {
    logic [SQ_W-1:0] r;
    logic [SQ_W-1:0] g;
    logic [SQ_W-1:0] b;
    logic [SQ_W-1:0] a;
  } sq_t;

  function automatic color_t pack_color(input logic [7:0] red, input logic [7:0] green,
                                        input logic [7:0] blue, input logic [7:0] alpha);
    color_t c;
    c.r = 5'(red   >> CHAN_SHIFT);
    c.g = 5'(green >> CHAN_SHIFT);
    c.b = 5'(blue  >> CHAN_SHIFT);
    c.a = 3'(alpha >> A_SHIFT);
    return c;
  endfunction

endpackage

[hw/rtl/npcs_ram.sv]
module npcs_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hw/rtl/npcs_dist.sv]
module npcs_dist (
  input  logic              clk,
  input  npcs_pkg::color_t  entry,
  input  npcs_pkg::color_t  query,
  output npcs_pkg::sq_t     sq
);

  logic [4:0] dr, dg, db;
  logic [2:0] da;
  logic [4:0] wa;

  always_comb begin
    dr = (entry.r > query.r) ? entry.r - query.r : query.r - entry.r;
    dg = (entry.g > query.g) ? entry.g - query.g : query.g - entry.g;
    db = (entry.b > query.b) ? entry.b - query.b : query.b - entry.b;
    da = (entry.a > query.a) ? entry.a - query.a : query.a - entry.a;
    wa = {da, 2'b00};  // alpha weight of 4
  end

  always_ff @(posedge clk) begin
    sq.r <= npcs_pkg::SQ_W'(dr) * npcs_pkg::SQ_W'(dr);
    sq.g <= npcs_pkg::SQ_W'(dg) * npcs_pkg::SQ_W'(dg);
    sq.b <= npcs_pkg::SQ_W'(db) * npcs_pkg::SQ_W'(db);
    sq.a <= npcs_pkg::SQ_W'(wa) * npcs_pkg::SQ_W'(wa);
  end

endmodule

[hw/rtl/nearest_palette_color_search.sv]
// Nearest palette color search.
// Slave stream: tuser is the command, tdata the entry slot and the 8-bit RGBA color.
// A write request (tuser 0) stores the color reduced to 5/5/5/3 bits in palette
// slot entry_index; slots at or above ENTRIES are dropped.
// Every slot must be written before the first query.
// A query request (tuser 1) scans the palette memory one entry per cycle through
// a read / square / accumulate pipeline and returns the lowest index at the
// minimum distance dr^2+dg^2+db^2+(4*da)^2 on the master stream.
// Each entry passes the palette read register, the squared-difference register
// and the accumulator; the result then goes to the output register. No new request
// is taken until the result is in the output register: one query at a time.
// If the receiver stalls, the finished result waits in the output register and
// a following result waits in the block with tready low on the slave side.
// cfg_data is use_alpha: 0 forces the query alpha to opaque. It is taken at any
// cycle (cfg_ready is always high) and should only change while idle.
// Reset (rst, synchronous) clears use_alpha and the control state; the palette
// content is undefined until written.
module nearest_palette_color_search #(
  parameter int ENTRIES = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // entry_index, red, green, blue, alpha
  input  logic        s_tuser,   // cmd
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // best_index, best_distance, zero pad
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data   // use_alpha
);

  localparam int AW = $clog2(ENTRIES);
  localparam logic [AW-1:0] LAST = AW'(ENTRIES - 1);

  typedef enum logic [1:0] {IDLE, SCAN, DONE} state_t;

  state_t                         state;
  logic                           use_alpha;
  logic [AW-1:0]                  cnt;
  logic                           issuing;
  logic                           v1, v2, last1, last2;
  logic [AW-1:0]                  idx1, idx2;
  npcs_pkg::color_t               query;
  npcs_pkg::color_t               in_color;
  npcs_pkg::color_t               q_color;
  npcs_pkg::color_t               rd_color;
  npcs_pkg::sq_t                  sq;
  logic [npcs_pkg::DIST_W-1:0]    dsum;
  logic [npcs_pkg::DIST_W-1:0]    best_d;
  logic [AW-1:0]                  best_i;
  logic                           in_acc;
  logic                           wr_en;

  assign s_tready  = (state == IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = s_tvalid && s_tready;

  always_comb begin
    in_color = npcs_pkg::pack_color(s_tdata[15:8], s_tdata[23:16], s_tdata[31:24],
                                    s_tdata[39:32]);
    q_color  = in_color;
    if (!use_alpha) begin
      q_color.a = 3'(npcs_pkg::ALPHA_LEVELS - 1);
    end
  end

  assign wr_en = in_acc && (s_tuser == npcs_pkg::CMD_WRITE) &&
                 (9'(s_tdata[7:0]) < 9'(ENTRIES));

  npcs_ram #(
    .WIDTH (npcs_pkg::COLOR_W),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (s_tdata[AW-1:0]),
    .wdata (in_color),
    .re    (issuing),
    .raddr (cnt),
    .rdata (rd_color)
  );

  npcs_dist u_dist (
    .clk   (clk),
    .entry (rd_color),
    .query (query),
    .sq    (sq)
  );

  assign dsum = npcs_pkg::DIST_W'(sq.r) + npcs_pkg::DIST_W'(sq.g) +
                npcs_pkg::DIST_W'(sq.b) + npcs_pkg::DIST_W'(sq.a);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      use_alpha <= 1'b0;
      issuing   <= 1'b0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        use_alpha <= cfg_data;
      end
      if (m_tvalid && m_tready && state != DONE) begin
        m_tvalid <= 1'b0;
      end

      v1    <= issuing;
      last1 <= (cnt == LAST);
      idx1  <= cnt;
      v2    <= v1;
      last2 <= last1;
      idx2  <= idx1;

      case (state)
        IDLE: begin
          if (in_acc && s_tuser == npcs_pkg::CMD_QUERY) begin
            query   <= q_color;
            cnt     <= '0;
            issuing <= 1'b1;
            best_d  <= '1;  // above any reachable distance
            state   <= SCAN;
          end
        end
        SCAN: begin
          if (issuing) begin
            cnt <= cnt + AW'(1);
            if (cnt == LAST) begin
              issuing <= 1'b0;
            end
          end
          if (v2) begin
            // strict compare keeps the lowest index on ties
            if (dsum < best_d) begin
              best_d <= dsum;
              best_i <= idx2;
            end
            if (last2) begin
              state <= DONE;
            end
          end
        end
        DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {4'b0000, best_d, 8'(best_i)};
            state    <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

[tb/tb_nearest_palette_color_search.sv]
module tb_nearest_palette_color_search;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS       = 256;
  localparam int SETTLE      = SLOTS + 8;
  localparam int STALL_LIMIT = 4000;

  typedef struct packed {
    logic       cmd;
    logic [7:0] slot;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } request_t;

  typedef struct packed {
    logic [7:0]  index;
    logic [11:0] distance;
  } match_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;   // entry_index, red, green, blue, alpha
  logic        s_tuser = 1'b0; // cmd
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;        // best_index, best_distance, zero pad
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_data = 1'b0; // use_alpha

  request_t         pending[$];
  match_t           expected_matches[$];
  npcs_pkg::color_t palette_model[SLOTS];
  logic [31:0]      gen_rgba[SLOTS];  // raw colors as queued, {a, b, g, r}
  logic             alpha_mode = 1'b0;
  logic             cfg_value = 1'b0;
  logic             steady = 1'b0;
  int               quiet = 0;
  int               errors = 0;
  int               cfg_count = 0;
  int               cfg_issued = 0;
  int               n_requests = 0;
  int               n_queries = 0;
  int               n_checked = 0;
  int               n_exact = 0;

  nearest_palette_color_search dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic npcs_pkg::color_t reduce_rgba(logic [7:0] r, logic [7:0] g,
                                                   logic [7:0] b, logic [7:0] a);
    npcs_pkg::color_t c;
    c.r = r[7:3];
    c.g = g[7:3];
    c.b = b[7:3];
    c.a = a[7:5];
    return c;
  endfunction

  // full scan, strict less-than keeps the lowest index on ties
  function automatic match_t predict_nearest(npcs_pkg::color_t q);
    match_t m;
    int     best;
    int     d;
    int     dr;
    int     dg;
    int     db;
    int     da;
    best = 1 << 20;
    m = '0;
    for (int i = 0; i < SLOTS; i++) begin
      dr = int'(palette_model[i].r) - int'(q.r);
      dg = int'(palette_model[i].g) - int'(q.g);
      db = int'(palette_model[i].b) - int'(q.b);
      da = 4 * (int'(palette_model[i].a) - int'(q.a));
      d = dr * dr + dg * dg + db * db + da * da;
      if (d < best) begin
        best = d;
        m.index = 8'(i);
      end
    end
    m.distance = 12'(best);
    return m;
  endfunction

  task automatic push_write(int slot, logic [31:0] rgba);
    request_t r;
    r.cmd = npcs_pkg::CMD_WRITE;
    r.slot = 8'(slot);
    {r.alpha, r.blue, r.green, r.red} = rgba;
    pending.push_back(r);
    gen_rgba[slot] = rgba;
  endtask

  task automatic push_query(logic [31:0] rgba);
    request_t r;
    r.cmd = npcs_pkg::CMD_QUERY;
    r.slot = 8'($urandom);
    {r.alpha, r.blue, r.green, r.red} = rgba;
    pending.push_back(r);
  endtask

  // mostly queries: exact hits (low bits scrambled), one-bit neighbors, random colors;
  // writes sometimes copy another slot so ties stay common
  task automatic random_mix(int count);
    logic [31:0] c;
    int          pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      c = gen_rgba[$urandom_range(SLOTS - 1)];
      if (pick < 40) begin
        if ($urandom_range(4) != 0) c = $urandom;
        push_write($urandom_range(SLOTS - 1), c);
      end else if (pick < 60) begin
        push_query((c & 32'hE0F8F8F8) | ($urandom & 32'h1F070707));
      end else if (pick < 75) begin
        push_query(c ^ (32'h1 << $urandom_range(31)));
      end else begin
        push_query($urandom);
      end
    end
  endtask

  // block must be idle before a register write; writes leave no result to wait on
  task automatic drain();
    do @(negedge clk);
    while (pending.size() != 0 || s_tvalid || expected_matches.size() != 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic set_alpha_mode(logic v);
    cfg_value = v;
    cfg_issued++;
    do @(negedge clk);
    while (cfg_count != cfg_issued);
  endtask

  always @(posedge clk) begin : drive
    request_t         nxt;
    npcs_pkg::color_t col;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        col = reduce_rgba(s_tdata[15:8], s_tdata[23:16], s_tdata[31:24], s_tdata[39:32]);
        if (s_tuser == npcs_pkg::CMD_WRITE) begin
          palette_model[s_tdata[7:0]] = col;
        end else begin
          if (!alpha_mode) col.a = 3'(npcs_pkg::ALPHA_LEVELS - 1);
          expected_matches.push_back(predict_nearest(col));
          n_queries++;
        end
        n_requests++;
      end
      if (!s_tvalid || s_tready) begin
        if (pending.size() != 0 && (steady || $urandom_range(99) >= 17)) begin
          nxt = pending.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= {nxt.alpha, nxt.blue, nxt.green, nxt.red, nxt.slot};
          s_tuser <= nxt.cmd;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : monitor
    match_t got;
    match_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.index = m_tdata[7:0];
        got.distance = m_tdata[19:8];
        if (expected_matches.size() == 0) begin
          errors++;
          $error("result with no query pending: best_index %0d best_distance %0d",
                 got.index, got.distance);
        end else begin
          want = expected_matches.pop_front();
          n_checked++;
          if (want.distance == 0) n_exact++;
          if (got.index !== want.index) begin
            errors++;
            $error("best_index: expected %0d, got %0d", want.index, got.index);
          end
          if (got.distance !== want.distance) begin
            errors++;
            $error("best_distance: expected %0d, got %0d", want.distance, got.distance);
          end
        end
      end
      m_tready <= steady || ($urandom_range(99) >= 17);
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      alpha_mode = 1'b0;
      cfg_valid <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      cfg_valid <= 1'b0;
      alpha_mode = cfg_data;
      cfg_count++;
    end else if (cfg_count != cfg_issued) begin
      cfg_valid <= 1'b1;
      cfg_data <= cfg_value;
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet >= STALL_LIMIT) begin
      $display("stalled for %0d cycles with %0d requests queued, %0d results owed",
               quiet, pending.size(), expected_matches.size());
      $display("tb_nearest_palette_color_search NOT OK");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    logic [31:0] shades[8];
    rst = 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // all-white palette: farthest corner, zero hit, low bits ignored
    set_alpha_mode(1'b1);
    for (int i = 0; i < SLOTS; i++) push_write(i, 32'hFFFFFFFF);
    push_query(32'h00000000);
    push_query(32'hFFFFFFFF);
    push_query(32'h1F070707);
    push_write(255, 32'h00000000);
    push_write(128, 32'hFF000000);
    push_write(200, 32'hFF000000);
    push_write(0, 32'h20181008);
    push_query(32'h00000000);
    push_query(32'hFF000000);
    push_query(32'hF0000000);   // ties slots 128 and 200
    push_query(32'h20181008);   // exact hit on slot 0
    push_query(32'h55AA55AA);
    push_query(32'hAA55AA55);
    drain();

    // query alpha forced opaque, stored alpha still counts
    set_alpha_mode(1'b0);
    push_query(32'h00000000);
    push_query(32'h00FFFFFF);
    push_query(32'h20181008);
    push_query(32'hFF000000);
    drain();

    set_alpha_mode(1'b1);
    for (int i = 0; i < SLOTS; i++) push_write(i, $urandom);
    random_mix(134);
    drain();

    set_alpha_mode(1'b0);
    random_mix(390);
    drain();

    // few distinct colors, no idling on either side
    set_alpha_mode(1'b1);
    steady = 1'b1;
    foreach (shades[k]) shades[k] = $urandom;
    for (int i = 0; i < SLOTS; i++) push_write(i, shades[$urandom_range(7)]);
    random_mix(134);
    drain();
    steady = 1'b0;

    set_alpha_mode(1'($urandom_range(1)));
    random_mix(390);
    drain();

    set_alpha_mode(1'b0);
    random_mix(117);
    drain();

    $display("%0d requests accepted, %0d of them queries; %0d results checked", n_requests,
             n_queries, n_checked);
    $display("%0d exact palette hits; use_alpha written %0d times, both settings",
             n_exact, cfg_count);
    if (errors == 0) begin
      $display("tb_nearest_palette_color_search OK");
    end else begin
      $display("tb_nearest_palette_color_search NOT OK");
    end
    $finish;
  end

endmodule
